// File: rtl/core/qdyn_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qdyn_pkg
// Shared widths, codes, micro-op table and CORDIC angle table of the
// quadrotor dynamics step.
// ----------------------------------------------------------------------------
package qdyn_pkg;

    localparam int FRAC_BITS_DEF = 16;
    localparam int ROTOR_W       = 20;
    localparam int DATA_W        = 32;
    localparam int PADDR_W       = 5;
    localparam int MEM_AW        = 5;
    localparam int MEM_DEPTH     = 32;
    localparam int NRES          = 12;
    localparam int OP_W          = 5;
    localparam int NOPS          = 21;
    localparam int SIN_W         = 34;
    localparam int CNT_W         = 5;
    localparam int CORDIC_STEPS  = 28;
    localparam int SHIFT_W       = 6;

    localparam logic [32:0] TWO_PI_Q30  = 33'd6746518852;
    localparam logic [32:0] PI_Q30      = 33'd3373259426;
    localparam logic [32:0] HALF_PI_Q30 = 33'd1686629713;
    localparam logic [32:0] GAIN_Q30    = 33'd652032874;

    // register indexes
    localparam logic [2:0] REG_LIFT = 3'd0;
    localparam logic [2:0] REG_DRAG = 3'd1;
    localparam logic [2:0] REG_INVM = 3'd2;
    localparam logic [2:0] REG_TSTEP = 3'd3;
    localparam logic [2:0] REG_SOM  = 3'd4;
    localparam logic [2:0] REG_SIR  = 3'd5;
    localparam logic [2:0] REG_SIP  = 3'd6;
    localparam logic [2:0] REG_SIY  = 3'd7;

    // operand A sources
    localparam logic [2:0] A_MEM  = 3'd0;
    localparam logic [2:0] A_SINE = 3'd1;
    localparam logic [2:0] A_RSUM = 3'd2;
    localparam logic [2:0] A_RL   = 3'd3;
    localparam logic [2:0] A_RM   = 3'd4;
    localparam logic [2:0] A_RN   = 3'd5;

    // coefficient selects
    localparam logic [3:0] K_GRAV = 4'd0;
    localparam logic [3:0] K_LIFT = 4'd1;
    localparam logic [3:0] K_DRAG = 4'd2;
    localparam logic [3:0] K_INVM = 4'd3;
    localparam logic [3:0] K_T    = 4'd4;
    localparam logic [3:0] K_SOM  = 4'd5;
    localparam logic [3:0] K_SIR  = 4'd6;
    localparam logic [3:0] K_SIP  = 4'd7;
    localparam logic [3:0] K_SIY  = 4'd8;

    // shift selects
    localparam logic [1:0] S_Q30  = 2'd0;
    localparam logic [1:0] S_CS   = 2'd1;
    localparam logic [1:0] S_FRAC = 2'd2;
    localparam logic [1:0] S_32   = 2'd3;

    // addend sources
    localparam logic [1:0] ADD_ZERO = 2'd0;
    localparam logic [1:0] ADD_GRAV = 2'd1;
    localparam logic [1:0] ADD_MEM  = 2'd2;

    // memory entries
    localparam logic [4:0] E_VU    = 5'd0;
    localparam logic [4:0] E_VV    = 5'd1;
    localparam logic [4:0] E_VW    = 5'd2;
    localparam logic [4:0] E_P     = 5'd3;
    localparam logic [4:0] E_Q     = 5'd4;
    localparam logic [4:0] E_R     = 5'd5;
    localparam logic [4:0] E_PX    = 5'd6;
    localparam logic [4:0] E_PY    = 5'd7;
    localparam logic [4:0] E_PZ    = 5'd8;
    localparam logic [4:0] E_PHI   = 5'd9;
    localparam logic [4:0] E_THETA = 5'd10;
    localparam logic [4:0] E_PSI   = 5'd11;
    localparam logic [4:0] E_FX    = 5'd12;
    localparam logic [4:0] E_FY    = 5'd13;
    localparam logic [4:0] E_FZ    = 5'd14;
    localparam logic [4:0] E_TL    = 5'd15;
    localparam logic [4:0] E_TM    = 5'd16;
    localparam logic [4:0] E_TN    = 5'd17;
    localparam logic [4:0] E_AX    = 5'd18;
    localparam logic [4:0] E_AY    = 5'd19;
    localparam logic [4:0] E_AZ    = 5'd20;

    // result slots
    localparam logic [3:0] SL_AX    = 4'd0;
    localparam logic [3:0] SL_AY    = 4'd1;
    localparam logic [3:0] SL_AZ    = 4'd2;
    localparam logic [3:0] SL_P     = 4'd3;
    localparam logic [3:0] SL_Q     = 4'd4;
    localparam logic [3:0] SL_R     = 4'd5;
    localparam logic [3:0] SL_PX    = 4'd6;
    localparam logic [3:0] SL_PY    = 4'd7;
    localparam logic [3:0] SL_PZ    = 4'd8;
    localparam logic [3:0] SL_PHI   = 4'd9;
    localparam logic [3:0] SL_THETA = 4'd10;
    localparam logic [3:0] SL_PSI   = 4'd11;
    localparam logic [3:0] SL_NONE  = 4'd15;

    typedef struct packed {
        logic [2:0]        a_src;
        logic [MEM_AW-1:0] a_ent;
        logic [3:0]        k_sel;
        logic [1:0]        s_sel;
        logic [1:0]        add_src;
        logic [MEM_AW-1:0] add_ent;
        logic              neg;
        logic [MEM_AW-1:0] dst;
        logic [3:0]        slot;
    } t_op;

    typedef struct packed {
        logic               start;
        logic [SIN_W-1:0]   opa;
        logic [DATA_W-1:0]  coef;
        logic [SHIFT_W-1:0] shift;
        logic [DATA_W-1:0]  addend;
        logic               neg;
    } t_mac_req;

    function automatic t_op mk_op(
        input logic [2:0] a_src, input logic [MEM_AW-1:0] a_ent,
        input logic [3:0] k_sel, input logic [1:0] s_sel,
        input logic [1:0] add_src, input logic [MEM_AW-1:0] add_ent,
        input logic neg, input logic [MEM_AW-1:0] dst, input logic [3:0] slot);
        t_op o;
        o.a_src   = a_src;
        o.a_ent   = a_ent;
        o.k_sel   = k_sel;
        o.s_sel   = s_sel;
        o.add_src = add_src;
        o.add_ent = add_ent;
        o.neg     = neg;
        o.dst     = dst;
        o.slot    = slot;
        return o;
    endfunction

    function automatic t_op op_desc(input logic [OP_W-1:0] idx);
        t_op o;
        case (idx)
            5'd0:  o = mk_op(A_SINE, E_THETA, K_GRAV, S_Q30, ADD_ZERO, E_FX, 1'b1, E_FX, SL_NONE);
            5'd1:  o = mk_op(A_SINE, E_PHI, K_GRAV, S_Q30, ADD_ZERO, E_FY, 1'b0, E_FY, SL_NONE);
            5'd2:  o = mk_op(A_RSUM, E_FZ, K_LIFT, S_CS, ADD_GRAV, E_FZ, 1'b1, E_FZ, SL_NONE);
            5'd3:  o = mk_op(A_MEM, E_FX, K_INVM, S_FRAC, ADD_ZERO, E_AX, 1'b0, E_AX, SL_AX);
            5'd4:  o = mk_op(A_MEM, E_FY, K_INVM, S_FRAC, ADD_ZERO, E_AY, 1'b0, E_AY, SL_AY);
            5'd5:  o = mk_op(A_MEM, E_FZ, K_INVM, S_FRAC, ADD_ZERO, E_AZ, 1'b0, E_AZ, SL_AZ);
            5'd6:  o = mk_op(A_RL, E_TL, K_LIFT, S_CS, ADD_ZERO, E_TL, 1'b0, E_TL, SL_NONE);
            5'd7:  o = mk_op(A_RM, E_TM, K_LIFT, S_CS, ADD_ZERO, E_TM, 1'b0, E_TM, SL_NONE);
            5'd8:  o = mk_op(A_RN, E_TN, K_DRAG, S_CS, ADD_ZERO, E_TN, 1'b0, E_TN, SL_NONE);
            5'd9:  o = mk_op(A_MEM, E_FX, K_SOM, S_FRAC, ADD_MEM, E_VU, 1'b0, E_VU, SL_NONE);
            5'd10: o = mk_op(A_MEM, E_FY, K_SOM, S_FRAC, ADD_MEM, E_VV, 1'b0, E_VV, SL_NONE);
            5'd11: o = mk_op(A_MEM, E_FZ, K_SOM, S_FRAC, ADD_MEM, E_VW, 1'b0, E_VW, SL_NONE);
            5'd12: o = mk_op(A_MEM, E_TL, K_SIR, S_FRAC, ADD_MEM, E_P, 1'b0, E_P, SL_P);
            5'd13: o = mk_op(A_MEM, E_TM, K_SIP, S_FRAC, ADD_MEM, E_Q, 1'b0, E_Q, SL_Q);
            5'd14: o = mk_op(A_MEM, E_TN, K_SIY, S_FRAC, ADD_MEM, E_R, 1'b0, E_R, SL_R);
            5'd15: o = mk_op(A_MEM, E_VU, K_T, S_32, ADD_MEM, E_PX, 1'b0, E_PX, SL_PX);
            5'd16: o = mk_op(A_MEM, E_VV, K_T, S_32, ADD_MEM, E_PY, 1'b0, E_PY, SL_PY);
            5'd17: o = mk_op(A_MEM, E_VW, K_T, S_32, ADD_MEM, E_PZ, 1'b0, E_PZ, SL_PZ);
            5'd18: o = mk_op(A_MEM, E_P, K_T, S_32, ADD_MEM, E_PHI, 1'b0, E_PHI, SL_PHI);
            5'd19: o = mk_op(A_MEM, E_Q, K_T, S_32, ADD_MEM, E_THETA, 1'b0, E_THETA, SL_THETA);
            5'd20: o = mk_op(A_MEM, E_R, K_T, S_32, ADD_MEM, E_PSI, 1'b0, E_PSI, SL_PSI);
            default: o = mk_op(A_MEM, E_VU, K_GRAV, S_Q30, ADD_ZERO, E_AX, 1'b0, E_AX,
                               SL_NONE);
        endcase
        return o;
    endfunction

    function automatic logic [SIN_W-1:0] atan_q30(input logic [CNT_W-1:0] i);
        logic [SIN_W-1:0] v;
        case (i)
            5'd0:  v = 34'h03243F6A8;
            5'd1:  v = 34'h01DAC6705;
            5'd2:  v = 34'h00FADBAFC;
            5'd3:  v = 34'h007F56EA6;
            5'd4:  v = 34'h003FEAB76;
            5'd5:  v = 34'h001FFD55B;
            5'd6:  v = 34'h000FFFAAA;
            5'd7:  v = 34'h0007FFF55;
            5'd8:  v = 34'h0003FFFEA;
            5'd9:  v = 34'h0001FFFFD;
            5'd10: v = 34'h0000FFFFF;
            5'd11: v = 34'h00007FFFF;
            5'd12: v = 34'h00003FFFF;
            5'd13: v = 34'h00001FFFF;
            5'd14: v = 34'h00000FFFF;
            5'd15: v = 34'h000007FFF;
            5'd16: v = 34'h000003FFF;
            5'd17: v = 34'h000001FFF;
            5'd18: v = 34'h000000FFF;
            5'd19: v = 34'h0000007FF;
            5'd20: v = 34'h0000003FF;
            5'd21: v = 34'h0000001FF;
            5'd22: v = 34'h0000000FF;
            5'd23: v = 34'h00000007F;
            5'd24: v = 34'h00000003F;
            5'd25: v = 34'h00000001F;
            5'd26: v = 34'h00000000F;
            5'd27: v = 34'h000000007;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

// File: rtl/core/qdyn_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qdyn request / response channels
// Valid/ready channels carrying rotor inputs and step results.
// ----------------------------------------------------------------------------
interface qdyn_req_if;
    logic                                valid;
    logic                                ready;
    logic [qdyn_pkg::ROTOR_W-1:0]        rotor1_sq;
    logic [qdyn_pkg::ROTOR_W-1:0]        rotor2_sq;
    logic [qdyn_pkg::ROTOR_W-1:0]        rotor3_sq;
    logic [qdyn_pkg::ROTOR_W-1:0]        rotor4_sq;

    modport source (output valid, rotor1_sq, rotor2_sq, rotor3_sq, rotor4_sq,
                    input ready);
    modport sink   (input valid, rotor1_sq, rotor2_sq, rotor3_sq, rotor4_sq,
                    output ready);
endinterface

interface qdyn_rsp_if;
    logic                               valid;
    logic                               ready;
    logic signed [qdyn_pkg::DATA_W-1:0] accel_x;
    logic signed [qdyn_pkg::DATA_W-1:0] accel_y;
    logic signed [qdyn_pkg::DATA_W-1:0] accel_z;
    logic signed [qdyn_pkg::DATA_W-1:0] roll_rate;
    logic signed [qdyn_pkg::DATA_W-1:0] pitch_rate;
    logic signed [qdyn_pkg::DATA_W-1:0] yaw_rate;
    logic signed [qdyn_pkg::DATA_W-1:0] pos_x;
    logic signed [qdyn_pkg::DATA_W-1:0] pos_y;
    logic signed [qdyn_pkg::DATA_W-1:0] pos_z;
    logic signed [qdyn_pkg::DATA_W-1:0] roll_angle;
    logic signed [qdyn_pkg::DATA_W-1:0] pitch_angle;
    logic signed [qdyn_pkg::DATA_W-1:0] yaw_angle;

    modport source (output valid, accel_x, accel_y, accel_z, roll_rate, pitch_rate,
                    yaw_rate, pos_x, pos_y, pos_z, roll_angle, pitch_angle, yaw_angle,
                    input ready);
    modport sink   (input valid, accel_x, accel_y, accel_z, roll_rate, pitch_rate,
                    yaw_rate, pos_x, pos_y, pos_z, roll_angle, pitch_angle, yaw_angle,
                    output ready);
endinterface

// File: rtl/core/qdyn_sine.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qdyn_sine
// Serial sine: reduction modulo 2*pi by reciprocal multiply and one
// correcting subtract, fold to [-pi/2, pi/2], then 28 rotation-mode CORDIC
// iterations, one per cycle.
// ----------------------------------------------------------------------------
module qdyn_sine #(
    parameter int FRAC_BITS = qdyn_pkg::FRAC_BITS_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_start,
    input  logic [qdyn_pkg::DATA_W-1:0]      i_angle,
    output logic                             o_done,
    output logic [qdyn_pkg::SIN_W-1:0]       o_sine
);
    localparam int AW     = 62 - FRAC_BITS;
    localparam int QW     = 30 - FRAC_BITS;
    localparam int SW     = qdyn_pkg::SIN_W;
    localparam int CW     = qdyn_pkg::CNT_W;

    // floor(2^32 / (2*pi))
    localparam logic [29:0]   INV_TWO_PI = 30'd683565275;
    localparam logic [AW-1:0] TP_EXT     = AW'(qdyn_pkg::TWO_PI_Q30);

    localparam logic [2:0] SS_IDLE = 3'd0;
    localparam logic [2:0] SS_QUO  = 3'd1;
    localparam logic [2:0] SS_REM  = 3'd2;
    localparam logic [2:0] SS_CORR = 3'd3;
    localparam logic [2:0] SS_FIX  = 3'd4;
    localparam logic [2:0] SS_FOLD = 3'd5;
    localparam logic [2:0] SS_ROT  = 3'd6;
    localparam logic [2:0] SS_DONE = 3'd7;

    logic [2:0]           r_st;
    logic [CW-1:0]        r_cnt;
    logic                 r_neg;
    logic [AW-1:0]        r_mag;
    logic [QW-1:0]        r_q;
    logic signed [SW-1:0] r_x, r_y, r_z;

    logic signed [AW-1:0] ang_ext;
    logic [AW-1:0]        q_full, q_mul;
    logic [32:0]          rem, wrap;
    logic signed [SW-1:0] z_fix, sx, sy, atn;
    logic signed [SW-1:0] pi_s, half_s, twopi_s;

    assign pi_s    = $signed({1'b0, qdyn_pkg::PI_Q30});
    assign half_s  = $signed({1'b0, qdyn_pkg::HALF_PI_Q30});
    assign twopi_s = $signed({1'b0, qdyn_pkg::TWO_PI_Q30});

    always_comb begin
        ang_ext = $signed({{(AW-32){i_angle[31]}}, i_angle}) <<< (30 - FRAC_BITS);
        // quotient estimate is exact or one short
        q_full  = {{30{1'b0}}, r_mag[AW-1:30]} * {{(AW-30){1'b0}}, INV_TWO_PI};
        q_mul   = {{(AW-QW){1'b0}}, r_q} * TP_EXT;
        rem     = r_mag[32:0];
        wrap    = (r_neg && rem != 33'd0) ? qdyn_pkg::TWO_PI_Q30 - rem : rem;
        z_fix   = (wrap >= qdyn_pkg::PI_Q30) ? $signed({1'b0, wrap}) - twopi_s
                                             : $signed({1'b0, wrap});
        sx      = r_x >>> r_cnt;
        sy      = r_y >>> r_cnt;
        atn     = $signed(qdyn_pkg::atan_q30(r_cnt));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st  <= SS_IDLE;
            r_cnt <= '0;
        end else begin
            case (r_st)
                SS_IDLE: begin
                    if (i_start) begin
                        r_st <= SS_QUO;
                    end
                end
                SS_QUO:  r_st <= SS_REM;
                SS_REM:  r_st <= SS_CORR;
                SS_CORR: r_st <= SS_FIX;
                SS_FIX:  r_st <= SS_FOLD;
                SS_FOLD: begin
                    r_st  <= SS_ROT;
                    r_cnt <= '0;
                end
                SS_ROT: begin
                    if (r_cnt == CW'(qdyn_pkg::CORDIC_STEPS - 1)) begin
                        r_st <= SS_DONE;
                    end else begin
                        r_cnt <= r_cnt + 1'b1;
                    end
                end
                SS_DONE: r_st <= SS_IDLE;
                default: r_st <= SS_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_st)
            SS_IDLE: begin
                if (i_start) begin
                    r_neg <= i_angle[31];
                    r_mag <= i_angle[31] ? AW'(-ang_ext) : AW'(ang_ext);
                end
            end
            SS_QUO: r_q <= q_full[AW-1:32];
            SS_REM: r_mag <= r_mag - q_mul;
            SS_CORR: begin
                if (r_mag >= TP_EXT) begin
                    r_mag <= r_mag - TP_EXT;
                end
            end
            SS_FIX: r_z <= z_fix;
            SS_FOLD: begin
                if (r_z > half_s) begin
                    r_z <= pi_s - r_z;
                end else if (r_z < -half_s) begin
                    r_z <= -pi_s - r_z;
                end
                r_x <= $signed({1'b0, qdyn_pkg::GAIN_Q30});
                r_y <= '0;
            end
            SS_ROT: begin
                if (!r_z[SW-1]) begin
                    r_x <= r_x - sy;
                    r_y <= r_y + sx;
                    r_z <= r_z - atn;
                end else begin
                    r_x <= r_x + sy;
                    r_y <= r_y - sx;
                    r_z <= r_z + atn;
                end
            end
            default: ;
        endcase
    end

    assign o_done = (r_st == SS_DONE);
    assign o_sine = r_y;

endmodule

// File: rtl/core/qdyn_mac.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qdyn_mac
// Three-stage multiply, round half away from zero, shift, add, saturate.
// ----------------------------------------------------------------------------
module qdyn_mac (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  qdyn_pkg::t_mac_req            i_req,
    output logic                          o_done,
    output logic [qdyn_pkg::DATA_W-1:0]   o_result
);
    localparam int SHW = qdyn_pkg::SHIFT_W;

    logic              r_v1, r_v2, r_v3;
    logic [63:0]       r_p1;
    logic              r_n1, r_n2;
    logic [SHW-1:0]    r_sh1;
    logic [31:0]       r_add1, r_add2;
    logic [64:0]       r_r2;
    logic [31:0]       r_res;

    logic [qdyn_pkg::SIN_W-1:0] mag;
    logic [64:0]                rnd;
    logic signed [66:0]         m67, val, sum;

    always_comb begin
        mag = i_req.opa[qdyn_pkg::SIN_W-1] ? (~i_req.opa + 1'b1) : i_req.opa;
        rnd = ({1'b0, r_p1} + (65'd1 << (r_sh1 - 1'b1))) >> r_sh1;
        m67 = $signed({2'b00, r_r2});
        val = r_n2 ? -m67 : m67;
        sum = $signed({{35{r_add2[31]}}, r_add2}) + val;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            r_v1 <= i_req.start;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        r_p1   <= mag[31:0] * i_req.coef;
        r_n1   <= i_req.opa[qdyn_pkg::SIN_W-1] ^ i_req.neg;
        r_sh1  <= i_req.shift;
        r_add1 <= i_req.addend;
        r_r2   <= rnd;
        r_n2   <= r_n1;
        r_add2 <= r_add1;
        if (sum > 67'sd2147483647) begin
            r_res <= 32'h7FFF_FFFF;
        end else if (sum < -67'sd2147483648) begin
            r_res <= 32'h8000_0000;
        end else begin
            r_res <= sum[31:0];
        end
    end

    assign o_done   = r_v3;
    assign o_result = r_res;

endmodule

// File: rtl/core/quadrotor_dynamics_step.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// quadrotor_dynamics_step
// One semi-implicit Euler tick of a quadrotor body, run as a micro-op
// sequence over a state memory, a shared multiply-round unit and a sine unit.
//
//   channel   dir  protocol   content
//   i_req     in   valid/rdy  rotor1_sq..rotor4_sq
//   o_rsp     out  valid/rdy  accelerations, rates, position, attitude
//   APB       in   psel/pen   eight 32-bit coefficient registers
//
// A request runs as 21 micro-ops through the one multiply-round unit, the
// first two after a sine evaluation; each reads the state memory, issues its
// operands and waits for the result, and after the last the result is loaded
// into the output register. Reset clears state through per-entry valid bits at
// once; no clearing pass. A new request is taken only in idle, also while the
// previous result waits in the output register; a stalled output holds the
// next result in staging until it drains.
// ----------------------------------------------------------------------------
module quadrotor_dynamics_step #(
    parameter int FRAC_BITS = qdyn_pkg::FRAC_BITS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    qdyn_req_if.sink                          i_req,
    qdyn_rsp_if.source                        o_rsp,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [qdyn_pkg::PADDR_W-1:0]      paddr,
    input  logic [qdyn_pkg::DATA_W-1:0]       pwdata,
    output logic [qdyn_pkg::DATA_W-1:0]       prdata,
    output logic                              pready
);
    localparam int DW = qdyn_pkg::DATA_W;
    localparam int RW = qdyn_pkg::ROTOR_W;
    localparam logic [DW-1:0] GRAV_Q = DW'(((64'd981 << FRAC_BITS) + 64'd50) / 64'd100);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_RD   = 3'd1;
    localparam logic [2:0] ST_OPR  = 3'd2;
    localparam logic [2:0] ST_SIN  = 3'd3;
    localparam logic [2:0] ST_MAC  = 3'd4;
    localparam logic [2:0] ST_OUT  = 3'd5;

    logic [2:0]                  r_state, n_state;
    logic [qdyn_pkg::OP_W-1:0]   r_op;
    logic [RW-1:0]               r_rot1, r_rot2, r_rot3, r_rot4;
    logic [DW-1:0]               r_lift, r_drag, r_invm, r_tstep;
    logic [DW-1:0]               r_som, r_sir, r_sip, r_siy;

    logic [DW-1:0]               r_mem [qdyn_pkg::MEM_DEPTH];
    logic [qdyn_pkg::MEM_DEPTH-1:0] r_vld;
    logic [DW-1:0]               r_rda, r_rdb;
    logic                        r_va, r_vb;

    logic [DW-1:0]               r_res [qdyn_pkg::NRES];
    logic [DW-1:0]               r_out [qdyn_pkg::NRES];
    logic                        r_out_valid;

    qdyn_pkg::t_op               desc;
    qdyn_pkg::t_mac_req          mreq;
    logic                        mac_done, sine_done, sine_start;
    logic [DW-1:0]               mac_res;
    logic [qdyn_pkg::SIN_W-1:0]  sine_y, a_val;
    logic [DW-1:0]               opa_mem, add_mem;
    logic [21:0]                 rsum;
    logic signed [22:0]          rl, rm, rn;
    logic                        in_acc, out_load, cfg_wr, last_op;

    assign desc    = qdyn_pkg::op_desc(r_op);
    assign in_acc  = i_req.valid && i_req.ready;
    assign i_req.ready = (r_state == ST_IDLE);
    assign out_load = (r_state == ST_OUT) && (!r_out_valid || o_rsp.ready);
    assign last_op  = (r_op == qdyn_pkg::OP_W'(qdyn_pkg::NOPS - 1));

    // configuration
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lift  <= '0;
            r_drag  <= '0;
            r_invm  <= '0;
            r_tstep <= '0;
            r_som   <= '0;
            r_sir   <= '0;
            r_sip   <= '0;
            r_siy   <= '0;
        end else if (cfg_wr) begin
            case (paddr[4:2])
                qdyn_pkg::REG_LIFT:  r_lift  <= pwdata;
                qdyn_pkg::REG_DRAG:  r_drag  <= pwdata;
                qdyn_pkg::REG_INVM:  r_invm  <= pwdata;
                qdyn_pkg::REG_TSTEP: r_tstep <= pwdata;
                qdyn_pkg::REG_SOM:   r_som   <= pwdata;
                qdyn_pkg::REG_SIR:   r_sir   <= pwdata;
                qdyn_pkg::REG_SIP:   r_sip   <= pwdata;
                qdyn_pkg::REG_SIY:   r_siy   <= pwdata;
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[4:2])
            qdyn_pkg::REG_LIFT:  prdata = r_lift;
            qdyn_pkg::REG_DRAG:  prdata = r_drag;
            qdyn_pkg::REG_INVM:  prdata = r_invm;
            qdyn_pkg::REG_TSTEP: prdata = r_tstep;
            qdyn_pkg::REG_SOM:   prdata = r_som;
            qdyn_pkg::REG_SIR:   prdata = r_sir;
            qdyn_pkg::REG_SIP:   prdata = r_sip;
            qdyn_pkg::REG_SIY:   prdata = r_siy;
            default:             prdata = '0;
        endcase
    end

    // sequencer
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: if (in_acc) n_state = ST_RD;
            ST_RD:   n_state = ST_OPR;
            ST_OPR:  n_state = (desc.a_src == qdyn_pkg::A_SINE) ? ST_SIN : ST_MAC;
            ST_SIN:  if (sine_done) n_state = ST_MAC;
            ST_MAC: begin
                if (mac_done) begin
                    n_state = last_op ? ST_OUT : ST_RD;
                end
            end
            ST_OUT:  if (out_load) n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_op        <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (in_acc) begin
                r_op <= '0;
            end else if (r_state == ST_MAC && mac_done && !last_op) begin
                r_op <= r_op + 1'b1;
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_rot1 <= i_req.rotor1_sq;
            r_rot2 <= i_req.rotor2_sq;
            r_rot3 <= i_req.rotor3_sq;
            r_rot4 <= i_req.rotor4_sq;
        end
    end

    // state memory: port A operand, port B addend, one write port
    always_ff @(posedge i_clk) begin
        if (r_state == ST_MAC && mac_done) begin
            r_mem[desc.dst] <= mac_res;
        end
        if (r_state == ST_RD) begin
            r_rda <= r_mem[desc.a_ent];
            r_rdb <= r_mem[desc.add_ent];
            r_va  <= r_vld[desc.a_ent];
            r_vb  <= r_vld[desc.add_ent];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (r_state == ST_MAC && mac_done) begin
            r_vld[desc.dst] <= 1'b1;
        end
    end

    assign opa_mem = r_va ? r_rda : '0;
    assign add_mem = r_vb ? r_rdb : '0;

    // operand selection
    always_comb begin
        rsum = {2'b00, r_rot1} + {2'b00, r_rot2} + {2'b00, r_rot3} + {2'b00, r_rot4};
        rl   = $signed({3'b000, r_rot4}) - $signed({3'b000, r_rot2});
        rm   = $signed({3'b000, r_rot1}) - $signed({3'b000, r_rot3});
        rn   = ($signed({3'b000, r_rot2}) + $signed({3'b000, r_rot4}))
             - ($signed({3'b000, r_rot1}) + $signed({3'b000, r_rot3}));
        case (desc.a_src)
            qdyn_pkg::A_MEM:  a_val = {{2{opa_mem[DW-1]}}, opa_mem};
            qdyn_pkg::A_RSUM: a_val = {12'd0, rsum};
            qdyn_pkg::A_RL:   a_val = {{11{rl[22]}}, rl};
            qdyn_pkg::A_RM:   a_val = {{11{rm[22]}}, rm};
            qdyn_pkg::A_RN:   a_val = {{11{rn[22]}}, rn};
            default:          a_val = '0;
        endcase

        mreq.start = ((r_state == ST_OPR) && (desc.a_src != qdyn_pkg::A_SINE))
                   || ((r_state == ST_SIN) && sine_done);
        mreq.opa   = (r_state == ST_SIN) ? sine_y : a_val;
        mreq.neg   = desc.neg;
        case (desc.k_sel)
            qdyn_pkg::K_GRAV: mreq.coef = GRAV_Q;
            qdyn_pkg::K_LIFT: mreq.coef = r_lift;
            qdyn_pkg::K_DRAG: mreq.coef = r_drag;
            qdyn_pkg::K_INVM: mreq.coef = r_invm;
            qdyn_pkg::K_T:    mreq.coef = r_tstep;
            qdyn_pkg::K_SOM:  mreq.coef = r_som;
            qdyn_pkg::K_SIR:  mreq.coef = r_sir;
            qdyn_pkg::K_SIP:  mreq.coef = r_sip;
            qdyn_pkg::K_SIY:  mreq.coef = r_siy;
            default:          mreq.coef = '0;
        endcase
        case (desc.s_sel)
            qdyn_pkg::S_Q30:  mreq.shift = qdyn_pkg::SHIFT_W'(30);
            qdyn_pkg::S_CS:   mreq.shift = qdyn_pkg::SHIFT_W'(32 - FRAC_BITS);
            qdyn_pkg::S_FRAC: mreq.shift = qdyn_pkg::SHIFT_W'(FRAC_BITS);
            qdyn_pkg::S_32:   mreq.shift = qdyn_pkg::SHIFT_W'(32);
            default:          mreq.shift = qdyn_pkg::SHIFT_W'(32);
        endcase
        case (desc.add_src)
            qdyn_pkg::ADD_GRAV: mreq.addend = GRAV_Q;
            qdyn_pkg::ADD_MEM:  mreq.addend = add_mem;
            default:            mreq.addend = '0;
        endcase
    end

    assign sine_start = (r_state == ST_OPR) && (desc.a_src == qdyn_pkg::A_SINE);

    qdyn_sine #(.FRAC_BITS(FRAC_BITS)) u_sine (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (sine_start),
        .i_angle (opa_mem),
        .o_done  (sine_done),
        .o_sine  (sine_y)
    );

    qdyn_mac u_mac (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_req    (mreq),
        .o_done   (mac_done),
        .o_result (mac_res)
    );

    // result staging and output register
    always_ff @(posedge i_clk) begin
        if (r_state == ST_MAC && mac_done && desc.slot != qdyn_pkg::SL_NONE) begin
            r_res[desc.slot] <= mac_res;
        end
        if (out_load) begin
            r_out <= r_res;
        end
    end

    assign o_rsp.valid       = r_out_valid;
    assign o_rsp.accel_x     = r_out[qdyn_pkg::SL_AX];
    assign o_rsp.accel_y     = r_out[qdyn_pkg::SL_AY];
    assign o_rsp.accel_z     = r_out[qdyn_pkg::SL_AZ];
    assign o_rsp.roll_rate   = r_out[qdyn_pkg::SL_P];
    assign o_rsp.pitch_rate  = r_out[qdyn_pkg::SL_Q];
    assign o_rsp.yaw_rate    = r_out[qdyn_pkg::SL_R];
    assign o_rsp.pos_x       = r_out[qdyn_pkg::SL_PX];
    assign o_rsp.pos_y       = r_out[qdyn_pkg::SL_PY];
    assign o_rsp.pos_z       = r_out[qdyn_pkg::SL_PZ];
    assign o_rsp.roll_angle  = r_out[qdyn_pkg::SL_PHI];
    assign o_rsp.pitch_angle = r_out[qdyn_pkg::SL_THETA];
    assign o_rsp.yaw_angle   = r_out[qdyn_pkg::SL_PSI];

    a_mac_in_mac: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mac_done |-> r_state == ST_MAC)
        else $error("multiply result outside MAC state");

    a_sine_in_sin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        sine_done |-> r_state == ST_SIN)
        else $error("sine result outside SIN state");

    a_last_to_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_MAC && mac_done && last_op) |=> r_state == ST_OUT)
        else $error("last micro-op did not hand off to output");

    a_out_from_seq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state) == ST_OUT)
        else $error("output valid raised without a finished request");

endmodule
